// ----- rtl/wtr_pkg.sv -----
// Shared types and constants for the transmit window ring.
package wtr_pkg;

  // Configuration register width and reset value
  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 11'd1024;

  // Fixed width of the sequence counters
  localparam int unsigned SEQ_W = 32;

  // Action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PEEK = 1'b1;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_t;

  // Flags carried from the lookup cycle to the result cycle
  typedef struct packed {
    logic is_push;
    logic hit;
    logic evict;
  } item_flags_t;

endpackage

// ----- rtl/transmit_window_ring_top.sv -----
// Transmit window ring: sequence-numbered descriptor store with eviction and lookup.
// The descriptor RAM is read at the transfer edge; the result load and write-back follow in the
// result state, which holds while the output stalls. A new item is not taken until the last
// one's result is loaded, because of the read-modify-write on the one RAM port pair.
// Reset: window empty (lead 0, trail 1), window_size 1024; RAM contents stay undefined
// until written, no clearing pass is run.
module transmit_window_ring_top
  import wtr_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 1024,
  parameter int unsigned LENGTH_BITS  = 16,
  parameter int unsigned HANDLE_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // request channel
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   action,
  input  logic [HANDLE_BITS-1:0] payload_handle,
  input  logic [LENGTH_BITS-1:0] payload_length,
  input  logic [SEQ_W-1:0]       query_sequence,
  // response channel
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic                   status,
  output logic [HANDLE_BITS-1:0] found_handle,
  output logic [LENGTH_BITS-1:0] found_length,
  output logic                   evicted_valid,
  output logic [HANDLE_BITS-1:0] evicted_handle,
  output logic [SEQ_W-1:0]       lead_sequence,
  output logic [SEQ_W-1:0]       trail_sequence
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned DATA_W = HANDLE_BITS + LENGTH_BITS;

  // Window state
  logic [CFG_W-1:0]  window_size;
  logic [SEQ_W-1:0]  lead_seq;
  logic [SEQ_W-1:0]  trail_seq;
  logic [SLOT_W-1:0] lead_slot;
  logic [CNT_W-1:0]  occ;

  // Controller
  state_t state, state_next;
  item_flags_t flags;
  logic [SLOT_W-1:0]      wslot;
  logic [HANDLE_BITS-1:0] item_handle;
  logic [LENGTH_BITS-1:0] item_length;

  logic req_xfer, rsp_load;

  // RAM
  logic [SLOT_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;
  logic              ram_we;

  // Effective window size: zero acts as one, clamp to depth
  logic [31:0]      ws_wide;
  logic [CNT_W-1:0] ws;
  always_comb begin
    if (window_size == '0) begin
      ws_wide = 32'd1;
    end else if ({21'd0, window_size} > WINDOW_DEPTH) begin
      ws_wide = WINDOW_DEPTH;
    end else begin
      ws_wide = {21'd0, window_size};
    end
    ws = ws_wide[CNT_W-1:0];
  end

  // Slot arithmetic
  logic [SUM_W-1:0]  ws_x, slot_x, next_x, peek_x, d_x;
  logic [SLOT_W-1:0] slot_cur, next_slot, peek_slot;
  logic [SEQ_W-1:0]  seq_back;
  logic              full, hit;

  always_comb begin
    ws_x = {1'b0, ws};
    slot_x = SUM_W'(lead_slot);
    if (slot_x >= ws_x) begin
      slot_x = '0;
    end
    slot_cur = slot_x[SLOT_W-1:0];

    // next slot for a push
    next_x = slot_x + SUM_W'(1);
    if (next_x == ws_x) begin
      next_x = '0;
    end
    next_slot = next_x[SLOT_W-1:0];
    full = (occ >= ws);

    // distance back from lead for a peek
    seq_back = lead_seq - query_sequence;
    hit  = (occ != '0) && (seq_back < SEQ_W'(occ));
    d_x  = {1'b0, seq_back[CNT_W-1:0]};
    if (slot_x >= d_x) begin
      peek_x = slot_x - d_x;
    end else begin
      peek_x = slot_x + ws_x - d_x;
    end
    peek_slot = peek_x[SLOT_W-1:0];
  end

  assign req_stall = (state != ST_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign raddr     = (action == ACT_PUSH) ? next_slot : peek_slot;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and result load
  always_comb begin
    state_next = state;
    rsp_load   = 1'b0;
    ram_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          ram_we     = flags.is_push;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Window counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
      lead_seq    <= '0;
      trail_seq   <= SEQ_W'(1);
      lead_slot   <= '0;
      occ         <= '0;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
      trail_seq   <= lead_seq + SEQ_W'(1);
      lead_slot   <= '0;
      occ         <= '0;
    end else if (req_xfer && action == ACT_PUSH) begin
      lead_seq  <= lead_seq + SEQ_W'(1);
      lead_slot <= next_slot;
      if (full) begin
        trail_seq <= trail_seq + SEQ_W'(1);
      end else begin
        occ <= occ + CNT_W'(1);
      end
    end else if (req_xfer) begin
      lead_slot <= slot_cur;
    end
  end

  // Item capture for the result cycle
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      flags.is_push <= (action == ACT_PUSH);
      flags.hit     <= (action == ACT_PEEK) && hit;
      flags.evict   <= (action == ACT_PUSH) && full;
      wslot         <= next_slot;
      item_handle   <= payload_handle;
      item_length   <= payload_length;
    end
  end

  // Descriptor store: handle in the upper bits, length in the lower
  wtr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot),
    .wdata ({item_handle, item_length}),
    .re    (req_xfer),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status         <= (!flags.is_push && !flags.hit) ? STATUS_MISS : STATUS_OK;
      found_handle   <= flags.hit ? rdata[DATA_W-1:LENGTH_BITS] : '0;
      found_length   <= flags.hit ? rdata[LENGTH_BITS-1:0] : '0;
      evicted_valid  <= flags.evict;
      evicted_handle <= flags.evict ? rdata[DATA_W-1:LENGTH_BITS] : '0;
      lead_sequence  <= lead_seq;
      trail_sequence <= trail_seq;
    end
  end

endmodule

// ----- rtl/wtr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module wtr_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
